// ----- design/afp_pkg.sv -----
// ----------------------------------------------------------------------------
// afp_pkg
// Shared types and constants of the serial API frame receive parser.
// ----------------------------------------------------------------------------
package afp_pkg;

    // result kinds
    localparam logic [1:0] KIND_RX_HDR  = 2'd0;
    localparam logic [1:0] KIND_RX_DATA = 2'd1;
    localparam logic [1:0] KIND_AT      = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_RX_TYPE    = 2'd1;
    localparam logic [1:0] CFG_AT_TYPE    = 2'd2;

    // configuration reset values
    localparam logic [7:0] RST_START_BYTE = 8'h7E;
    localparam logic [7:0] RST_RX_TYPE    = 8'h90;
    localparam logic [7:0] RST_AT_TYPE    = 8'h88;

    // frame layout
    localparam logic [7:0]  SUM_INIT      = 8'hFF;
    localparam logic [15:0] RX_MIN_LEN    = 16'd13;
    localparam logic [3:0]  HDR_RX_BYTES  = 4'd12;
    localparam logic [3:0]  HDR_AT_BYTES  = 4'd5;
    localparam int          DATA_BASE     = 12;

    // configuration registers as seen by the parser
    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] receive_type;
        logic [7:0] at_response_type;
    } t_cfg;

    // request from the parser to the result sequencer
    typedef struct packed {
        logic        start;
        logic        is_at;
        logic [15:0] count;
    } t_emit_req;

endpackage

// ----- design/api_frame_receive_parser.sv -----
// ----------------------------------------------------------------------------
// api_frame_receive_parser
// Recovers API frames from a received serial byte stream and reports
// receive packets and AT command responses.
// ----------------------------------------------------------------------------
// Usage:
// - rx channel (i_rx_valid / o_rx_ready / i_rx_byte) carries one serial byte
//   per transaction; while parsing, a byte is taken every clock cycle.
// - result channel (o_res_valid / i_res_ready) carries one result per
//   transaction; o_last marks the final result of a frame.
// - config port: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
//   (0 start byte, 1 receive type, 2 AT response type) at the clock edge.
// - body bytes are written into the body memory (one write port, one read
//   port) as they arrive; after a good checksum the result sequencer reads
//   them back while o_rx_ready is low.
// - after the checksum byte the sequencer reads the header bytes back, then
//   loads the output register; each data result takes a registered memory
//   read plus an output register load; receiver stalls delay these steps.
// - a stalled receiver holds the result register and keeps o_rx_ready low.
// - reset (synchronous, active low) returns the parser to idle and restores
//   the register defaults; the body memory is not cleared.
// ----------------------------------------------------------------------------
module api_frame_receive_parser #(
    parameter int STORE_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_kind,
    output logic [63:0] o_source_long_address,
    output logic [15:0] o_source_short_address,
    output logic [7:0]  o_receive_options,
    output logic [7:0]  o_message_id,
    output logic [5:0]  o_data_count,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_frame_id,
    output logic [15:0] o_at_command,
    output logic [7:0]  o_command_status,
    output logic [7:0]  o_command_data,
    output logic        o_last
);
    import afp_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    t_cfg      r_cfg;
    t_emit_req w_req;
    logic          w_busy;
    logic          w_accept;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte       <= RST_START_BYTE;
            r_cfg.receive_type     <= RST_RX_TYPE;
            r_cfg.at_response_type <= RST_AT_TYPE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_START_BYTE: r_cfg.start_byte       <= i_cfg_data;
                CFG_RX_TYPE:    r_cfg.receive_type     <= i_cfg_data;
                CFG_AT_TYPE:    r_cfg.at_response_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stalls while results are read out of the store
    assign o_rx_ready = !w_busy;
    assign w_accept   = i_rx_valid && o_rx_ready;

    afp_parse #(.STORE_BYTES(STORE_BYTES)) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (w_accept),
        .i_byte    (i_rx_byte),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_req     (w_req)
    );

    afp_store #(.STORE_BYTES(STORE_BYTES)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    afp_emit #(.STORE_BYTES(STORE_BYTES)) u_emit (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_req                  (w_req),
        .o_busy                 (w_busy),
        .o_rd_addr              (w_rd_addr),
        .i_rd_data              (w_rd_data),
        .o_valid                (o_res_valid),
        .i_ready                (i_res_ready),
        .o_kind                 (o_kind),
        .o_source_long_address  (o_source_long_address),
        .o_source_short_address (o_source_short_address),
        .o_receive_options      (o_receive_options),
        .o_message_id           (o_message_id),
        .o_data_count           (o_data_count),
        .o_data_byte            (o_data_byte),
        .o_frame_id             (o_frame_id),
        .o_at_command           (o_at_command),
        .o_command_status       (o_command_status),
        .o_command_data         (o_command_data),
        .o_last                 (o_last)
    );

`ifndef SYNTH
    // store is never written while it is being read out
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_wr_en)
        else $error("body store written during readout");

    // a launched frame makes the sequencer busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> w_busy)
        else $error("sequencer did not take a frame");

    // results only appear during readout
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> w_busy)
        else $error("result valid while sequencer idle");

    // final result of a frame frees the input
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_last) |=> !w_busy)
        else $error("sequencer still busy after last result");
`endif

endmodule

// ----- design/afp_store.sv -----
// ----------------------------------------------------------------------------
// afp_store
// Body byte memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module afp_store #(
    parameter int STORE_BYTES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(STORE_BYTES)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic [$clog2(STORE_BYTES)-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/afp_parse.sv -----
// ----------------------------------------------------------------------------
// afp_parse
// Byte-level frame parser: delimiter, length, type, body into the store,
// checksum check, and launch of the result sequencer on a good frame.
// ----------------------------------------------------------------------------
module afp_parse #(
    parameter int STORE_BYTES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  afp_pkg::t_cfg                  i_cfg,
    input  logic                           i_accept,
    input  logic [7:0]                     i_byte,
    output logic                           o_wr_en,
    output logic [$clog2(STORE_BYTES)-1:0] o_wr_addr,
    output logic [7:0]                     o_wr_data,
    output afp_pkg::t_emit_req             o_req
);
    import afp_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [15:0] MaxLen = 16'(STORE_BYTES);

    typedef enum logic [2:0] {
        P_IDLE, P_LEN_HI, P_LEN_LO, P_TYPE, P_BODY, P_CHECK
    } t_phase;

    t_phase      r_phase;
    logic [15:0] r_len;
    logic [AW:0] r_cnt;
    logic [7:0]  r_sum;
    logic [7:0]  r_type;

    logic [AW:0] n_cnt;
    logic [16:0] w_cnt_plus;
    logic [15:0] w_len_full;
    logic        w_is_rx;
    logic        w_is_at;
    logic        w_good;

    assign n_cnt      = r_cnt + 1'b1;
    assign w_cnt_plus = 17'(n_cnt) + 17'd1;
    assign w_len_full = {r_len[15:8], i_byte};
    assign w_is_rx    = (r_type == i_cfg.receive_type);
    assign w_is_at    = (r_type == i_cfg.at_response_type);

    // body bytes go straight into the store
    assign o_wr_en   = i_accept && (r_phase == P_BODY);
    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = i_byte;

    // launch decision at the checksum byte
    always_comb begin
        w_good = i_accept && (r_phase == P_CHECK) && (r_sum == i_byte);
        o_req.start = w_good && (w_is_rx ? (r_len >= RX_MIN_LEN) : w_is_at);
        o_req.is_at = !w_is_rx;
        o_req.count = r_len - RX_MIN_LEN;
    end

    // phase sequencing and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= SUM_INIT;
            r_type  <= '0;
        end else if (i_accept) begin
            unique case (r_phase)
                P_IDLE: begin
                    if (i_byte == i_cfg.start_byte) begin
                        r_cnt   <= '0;
                        r_sum   <= SUM_INIT;
                        r_phase <= P_LEN_HI;
                    end
                end
                P_LEN_HI: begin
                    r_len[15:8] <= i_byte;
                    r_sum       <= r_sum - i_byte;
                    r_phase     <= P_LEN_LO;
                end
                P_LEN_LO: begin
                    r_len[7:0] <= i_byte;
                    if (w_len_full <= MaxLen) begin
                        r_sum   <= SUM_INIT;
                        r_phase <= P_TYPE;
                    end else begin
                        r_phase <= P_IDLE;
                    end
                end
                P_TYPE: begin
                    r_type <= i_byte;
                    if (i_byte == i_cfg.receive_type || i_byte == i_cfg.at_response_type) begin
                        r_sum   <= r_sum - i_byte;
                        r_phase <= P_BODY;
                    end else begin
                        r_phase <= P_IDLE;
                    end
                end
                P_BODY: begin
                    r_cnt <= n_cnt;
                    r_sum <= r_sum - i_byte;
                    // body done once the count reaches length minus one
                    if (w_cnt_plus >= 17'(r_len)) begin
                        r_phase <= P_CHECK;
                    end
                end
                P_CHECK: begin
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/afp_emit.sv -----
// ----------------------------------------------------------------------------
// afp_emit
// Result sequencer: reads the header bytes and data bytes of a good frame
// back out of the store and presents them one result at a time.
// ----------------------------------------------------------------------------
module afp_emit #(
    parameter int STORE_BYTES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  afp_pkg::t_emit_req             i_req,
    output logic                           o_busy,
    output logic [$clog2(STORE_BYTES)-1:0] o_rd_addr,
    input  logic [7:0]                     i_rd_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_kind,
    output logic [63:0]                    o_source_long_address,
    output logic [15:0]                    o_source_short_address,
    output logic [7:0]                     o_receive_options,
    output logic [7:0]                     o_message_id,
    output logic [5:0]                     o_data_count,
    output logic [7:0]                     o_data_byte,
    output logic [7:0]                     o_frame_id,
    output logic [15:0]                    o_at_command,
    output logic [7:0]                     o_command_status,
    output logic [7:0]                     o_command_data,
    output logic                           o_last
);
    import afp_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(STORE_BYTES + 1);

    typedef enum logic [2:0] {
        E_IDLE, E_HDR, E_HLOAD, E_DRD, E_DCAP, E_OUT
    } t_estate;

    t_estate     r_state;
    logic [3:0]  r_step;
    logic [3:0]  r_hdr_n;
    logic [95:0] r_hdr;
    logic        r_is_at;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_left;

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [63:0] r_long;
    logic [15:0] r_short;
    logic [7:0]  r_opt;
    logic [7:0]  r_msg;
    logic [5:0]  r_dcnt;
    logic [7:0]  r_dbyte;
    logic [7:0]  r_fid;
    logic [15:0] r_cmd;
    logic [7:0]  r_stat;
    logic [7:0]  r_cdata;
    logic        r_last;

    logic [15:0] w_count16;

    assign w_count16 = 16'(r_count);
    assign o_busy    = (r_state != E_IDLE);
    assign o_rd_addr = (r_state == E_HDR) ? AW'(r_step) : r_addr;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.start) begin
                        r_step  <= '0;
                        r_hdr_n <= i_req.is_at ? HDR_AT_BYTES : HDR_RX_BYTES;
                        r_is_at <= i_req.is_at;
                        r_count <= i_req.count[CW-1:0];
                        r_state <= E_HDR;
                    end
                end
                E_HDR: begin
                    // captured read data belongs to the previous step's read address
                    if (r_step != 4'd0) begin
                        r_hdr <= {r_hdr[87:0], i_rd_data};
                    end
                    if (r_step == r_hdr_n) begin
                        r_state <= E_HLOAD;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                E_HLOAD: begin
                    r_valid <= 1'b1;
                    r_dbyte <= '0;
                    if (r_is_at) begin
                        r_kind  <= KIND_AT;
                        r_long  <= '0;
                        r_short <= '0;
                        r_opt   <= '0;
                        r_msg   <= '0;
                        r_dcnt  <= '0;
                        r_fid   <= r_hdr[39:32];
                        r_cmd   <= r_hdr[31:16];
                        r_stat  <= r_hdr[15:8];
                        r_cdata <= r_hdr[7:0];
                        r_last  <= 1'b1;
                    end else begin
                        r_kind  <= KIND_RX_HDR;
                        r_long  <= r_hdr[95:32];
                        r_short <= r_hdr[31:16];
                        r_opt   <= r_hdr[15:8];
                        r_msg   <= r_hdr[7:0];
                        r_dcnt  <= w_count16[5:0];
                        r_fid   <= '0;
                        r_cmd   <= '0;
                        r_stat  <= '0;
                        r_cdata <= '0;
                        r_last  <= (r_count == '0);
                    end
                    r_state <= E_OUT;
                end
                E_DRD: begin
                    r_state <= E_DCAP;
                end
                E_DCAP: begin
                    r_valid <= 1'b1;
                    r_kind  <= KIND_RX_DATA;
                    r_long  <= '0;
                    r_short <= '0;
                    r_opt   <= '0;
                    r_msg   <= '0;
                    r_dcnt  <= '0;
                    r_dbyte <= i_rd_data;
                    r_fid   <= '0;
                    r_cmd   <= '0;
                    r_stat  <= '0;
                    r_cdata <= '0;
                    r_last  <= (r_left == CW'(1));
                    r_state <= E_OUT;
                end
                E_OUT: begin
                    // hold the result until the transaction completes
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= E_IDLE;
                        end else if (r_kind == KIND_RX_HDR) begin
                            r_addr  <= AW'(DATA_BASE);
                            r_left  <= r_count;
                            r_state <= E_DRD;
                        end else begin
                            r_addr  <= r_addr + 1'b1;
                            r_left  <= r_left - 1'b1;
                            r_state <= E_DRD;
                        end
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid                = r_valid;
    assign o_kind                 = r_kind;
    assign o_source_long_address  = r_long;
    assign o_source_short_address = r_short;
    assign o_receive_options      = r_opt;
    assign o_message_id           = r_msg;
    assign o_data_count           = r_dcnt;
    assign o_data_byte            = r_dbyte;
    assign o_frame_id             = r_fid;
    assign o_at_command           = r_cmd;
    assign o_command_status       = r_stat;
    assign o_command_data         = r_cdata;
    assign o_last                 = r_last;

endmodule

// ----- verif/afp_frame_checker.sv -----
// ----------------------------------------------------------------------------
// afp_frame_checker
// Watches the byte, config and result channels of the frame receive parser,
// predicts the results of every accepted frame and compares them in order.
// ----------------------------------------------------------------------------
module afp_frame_checker
    import afp_pkg::*;
#(
    parameter int STORE_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_source_long_address,
    input  logic [15:0] i_source_short_address,
    input  logic [7:0]  i_receive_options,
    input  logic [7:0]  i_message_id,
    input  logic [5:0]  i_data_count,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_frame_id,
    input  logic [15:0] i_at_command,
    input  logic [7:0]  i_command_status,
    input  logic [7:0]  i_command_data,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_TYPE,
        ST_BODY,
        ST_CHECK
    } t_parse_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] long_addr;
        logic [15:0] short_addr;
        logic [7:0]  options;
        logic [7:0]  msg_id;
        logic [5:0]  data_count;
        logic [7:0]  data_byte;
        logic [7:0]  frame_id;
        logic [15:0] at_cmd;
        logic [7:0]  status;
        logic [7:0]  cmd_data;
        logic        last;
    } t_frame_result;

    t_frame_result predicted_results[$];
    t_frame_result seen;
    t_frame_result want;

    // shadow copy of the config registers
    logic [7:0] start_byte;
    logic [7:0] rx_type;
    logic [7:0] at_type;

    // shadow copy of the parser state
    t_parse_state state;
    logic [15:0]  frame_len;
    int           body_cnt;
    logic [7:0]   sum_left;
    logic [7:0]   frame_type;
    logic [7:0]   body_mem [STORE_BYTES];

    int fails = 0;

    assign o_fail_count = fails;

    function automatic logic [7:0] body_byte(input int idx);
        return (idx < STORE_BYTES) ? body_mem[idx] : 8'h00;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            fails++;
        end
    endtask

    // results of a frame whose checksum matched
    task automatic queue_frame_results();
        t_frame_result r;
        int n;
        int i;
        if (frame_type == rx_type) begin
            if (frame_len >= RX_MIN_LEN) begin
                n = frame_len - RX_MIN_LEN;
                r = '0;
                r.kind = KIND_RX_HDR;
                for (i = 0; i < 8; i++)
                    r.long_addr = {r.long_addr[55:0], body_byte(i)};
                r.short_addr = {body_byte(8), body_byte(9)};
                r.options    = body_byte(10);
                r.msg_id     = body_byte(11);
                r.data_count = n[5:0];
                r.last       = (n == 0);
                predicted_results.push_back(r);
                for (i = 0; i < n; i++) begin
                    r = '0;
                    r.kind      = KIND_RX_DATA;
                    r.data_byte = body_byte(DATA_BASE + i);
                    r.last      = (i + 1 == n);
                    predicted_results.push_back(r);
                end
            end
        end else if (frame_type == at_type) begin
            r = '0;
            r.kind     = KIND_AT;
            r.frame_id = body_byte(0);
            r.at_cmd   = {body_byte(1), body_byte(2)};
            r.status   = body_byte(3);
            r.cmd_data = body_byte(4);
            r.last     = 1'b1;
            predicted_results.push_back(r);
        end
    endtask

    // one accepted serial byte through the frame state machine
    task automatic parse_rx_byte(input logic [7:0] b);
        case (state)
            ST_IDLE: begin
                if (b == start_byte) begin
                    body_cnt = 0;
                    sum_left = SUM_INIT;
                    state    = ST_LEN_HI;
                end
            end
            ST_LEN_HI: begin
                frame_len = {b, frame_len[7:0]};
                sum_left  = sum_left - b;
                state     = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                frame_len = {frame_len[15:8], b};
                if (frame_len <= STORE_BYTES) begin
                    sum_left = SUM_INIT;
                    state    = ST_TYPE;
                end else begin
                    state = ST_IDLE;
                end
            end
            ST_TYPE: begin
                frame_type = b;
                if (b == rx_type || b == at_type) begin
                    sum_left = sum_left - b;
                    state    = ST_BODY;
                end else begin
                    state = ST_IDLE;
                end
            end
            ST_BODY: begin
                if (body_cnt < STORE_BYTES)
                    body_mem[body_cnt] = b;
                body_cnt++;
                sum_left = sum_left - b;
                if (body_cnt + 1 >= frame_len)
                    state = ST_CHECK;
            end
            ST_CHECK: begin
                if (sum_left == b)
                    queue_frame_results();
                state = ST_IDLE;
            end
            default: state = ST_IDLE;
        endcase
    endtask

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_byte = RST_START_BYTE;
            rx_type    = RST_RX_TYPE;
            at_type    = RST_AT_TYPE;
            state      = ST_IDLE;
            frame_len  = '0;
            body_cnt   = 0;
            sum_left   = SUM_INIT;
            frame_type = '0;
            predicted_results.delete();
        end else begin
            // result transaction against the oldest prediction
            if (i_res_valid && i_res_ready) begin
                seen = '{i_kind, i_source_long_address, i_source_short_address,
                         i_receive_options, i_message_id, i_data_count, i_data_byte,
                         i_frame_id, i_at_command, i_command_status, i_command_data,
                         i_last};
                if (predicted_results.size() == 0) begin
                    $error("unexpected result transaction, kind %0d", i_kind);
                    fails++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("kind", want.kind, seen.kind);
                    check_field("source_long_address", want.long_addr, seen.long_addr);
                    check_field("source_short_address", want.short_addr, seen.short_addr);
                    check_field("receive_options", want.options, seen.options);
                    check_field("message_id", want.msg_id, seen.msg_id);
                    check_field("data_count", want.data_count, seen.data_count);
                    check_field("data_byte", want.data_byte, seen.data_byte);
                    check_field("frame_id", want.frame_id, seen.frame_id);
                    check_field("at_command", want.at_cmd, seen.at_cmd);
                    check_field("command_status", want.status, seen.status);
                    check_field("command_data", want.cmd_data, seen.cmd_data);
                    check_field("last", want.last, seen.last);
                end
            end
            // config writes take effect at once
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_START_BYTE: start_byte = i_cfg_data;
                    CFG_RX_TYPE:    rx_type    = i_cfg_data;
                    CFG_AT_TYPE:    at_type    = i_cfg_data;
                    default: ;
                endcase
            end
            // byte transaction
            if (i_rx_valid && i_rx_ready)
                parse_rx_byte(i_rx_byte);
        end
        o_pending = predicted_results.size();
    end

endmodule

// ----- verif/tb_api_frame_receive_parser.sv -----
// ----------------------------------------------------------------------------
// tb_api_frame_receive_parser
// Feeds framed and broken serial byte streams to the frame receive parser
// under several register settings, with random gaps on both channels and a
// long result stall, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_api_frame_receive_parser;
    import afp_pkg::*;

    localparam int STORE_BYTES  = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RUN_LIMIT    = 4000000;
    localparam int PHASE_BYTES  = 4;
    localparam int STEADY_BYTES = 30;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_START
    } t_fill;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_wr_en  = 1'b0;
    logic [1:0]  i_cfg_index  = CFG_START_BYTE;
    logic [7:0]  i_cfg_data   = 8'h00;
    logic        i_rx_valid   = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte    = 8'h00;
    logic        o_res_valid;
    logic        i_res_ready  = 1'b0;
    logic [1:0]  o_kind;
    logic [63:0] o_source_long_address;
    logic [15:0] o_source_short_address;
    logic [7:0]  o_receive_options;
    logic [7:0]  o_message_id;
    logic [5:0]  o_data_count;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_frame_id;
    logic [15:0] o_at_command;
    logic [7:0]  o_command_status;
    logic [7:0]  o_command_data;
    logic        o_last;

    int fail_count;
    int pending;

    // register values currently programmed
    logic [7:0] cur_start = RST_START_BYTE;
    logic [7:0] cur_rx    = RST_RX_TYPE;
    logic [7:0] cur_at    = RST_AT_TYPE;

    bit steady   = 1'b0;
    bit hold_req = 1'b0;
    int frame_bytes = 0;

    api_frame_receive_parser #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_rx_valid            (i_rx_valid),
        .o_rx_ready            (o_rx_ready),
        .i_rx_byte             (i_rx_byte),
        .o_res_valid           (o_res_valid),
        .i_res_ready           (i_res_ready),
        .o_kind                (o_kind),
        .o_source_long_address (o_source_long_address),
        .o_source_short_address(o_source_short_address),
        .o_receive_options     (o_receive_options),
        .o_message_id          (o_message_id),
        .o_data_count          (o_data_count),
        .o_data_byte           (o_data_byte),
        .o_frame_id            (o_frame_id),
        .o_at_command          (o_at_command),
        .o_command_status      (o_command_status),
        .o_command_data        (o_command_data),
        .o_last                (o_last)
    );

    afp_frame_checker #(
        .STORE_BYTES(STORE_BYTES)
    ) u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_rx_valid            (i_rx_valid),
        .i_rx_ready            (o_rx_ready),
        .i_rx_byte             (i_rx_byte),
        .i_res_valid           (o_res_valid),
        .i_res_ready           (i_res_ready),
        .i_kind                (o_kind),
        .i_source_long_address (o_source_long_address),
        .i_source_short_address(o_source_short_address),
        .i_receive_options     (o_receive_options),
        .i_message_id          (o_message_id),
        .i_data_count          (o_data_count),
        .i_data_byte           (o_data_byte),
        .i_frame_id            (o_frame_id),
        .i_at_command          (o_at_command),
        .i_command_status      (o_command_status),
        .i_command_data        (o_command_data),
        .i_last                (o_last),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // one byte transaction, entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input bit counted);
        while (!steady && $urandom_range(0, 99) < 31) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (counted)
            frame_bytes++;
    endtask

    // program all three registers on consecutive cycles
    task automatic write_config(input logic [7:0] start_val, input logic [7:0] rx_val,
                                input logic [7:0] at_val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_START_BYTE;
        i_cfg_data  <= start_val;
        @(negedge i_clk);
        i_cfg_index <= CFG_RX_TYPE;
        i_cfg_data  <= rx_val;
        @(negedge i_clk);
        i_cfg_index <= CFG_AT_TYPE;
        i_cfg_data  <= at_val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_start = start_val;
        cur_rx    = rx_val;
        cur_at    = at_val;
    endtask

    // wait for every predicted result plus the sequencer tail
    task automatic drain();
        i_rx_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // start, length, type, body and checksum; stops early where the parser aborts
    task automatic send_frame(input logic [15:0] len, input logic [7:0] ftype,
                              input t_fill fill, input bit bad_sum);
        logic [7:0] sum_left;
        logic [7:0] b;
        int nbody;
        push_byte(cur_start, 1'b1);
        push_byte(len[15:8], 1'b1);
        push_byte(len[7:0], 1'b1);
        if (len <= STORE_BYTES) begin
            push_byte(ftype, 1'b1);
            if (ftype == cur_rx || ftype == cur_at) begin
                nbody = (len <= 1) ? 1 : len - 1;
                sum_left = SUM_INIT - ftype;
                for (int i = 0; i < nbody; i++) begin
                    case (fill)
                        FILL_ZERO: b = 8'h00;
                        FILL_ONES: b = 8'hFF;
                        FILL_START: b = ($urandom_range(0, 3) == 0) ? cur_start
                                                                    : 8'($urandom_range(0, 255));
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    sum_left = sum_left - b;
                    push_byte(b, 1'b1);
                end
                if (bad_sum)
                    sum_left = sum_left ^ 8'($urandom_range(1, 255));
                push_byte(sum_left, 1'b1);
            end
        end
    endtask

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic random_traffic(input int target);
        int goal;
        int r;
        int n;
        logic [7:0] t;
        t_fill fill;
        goal = frame_bytes + target;
        while (frame_bytes < goal) begin
            r = $urandom_range(0, 99);
            fill = t_fill'($urandom_range(0, 3));
            if (r < 40) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64) : $urandom_range(13, 20);
                send_frame(16'(n), cur_rx, fill, 1'b0);
            end else if (r < 70) begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 12);
                send_frame(16'(n), cur_at, fill, 1'b0);
            end else if (r < 78) begin
                t = $urandom_range(0, 1) ? cur_rx : cur_at;
                send_frame(16'($urandom_range(0, 20)), t, fill, 1'b1);
            end else if (r < 84) begin
                send_frame(16'($urandom_range(0, 12)), cur_rx, fill, 1'b0);
            end else if (r < 89) begin
                send_frame(16'($urandom_range(STORE_BYTES + 1, 65535)), cur_rx, fill, 1'b0);
            end else if (r < 94) begin
                do t = 8'($urandom_range(0, 255)); while (t == cur_rx || t == cur_at);
                send_frame(16'($urandom_range(0, STORE_BYTES)), t, fill, 1'b0);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (steady) begin
                i_res_ready <= 1'b1;
            end else begin
                i_res_ready <= ($urandom_range(0, 99) >= 31);
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [7:0] same_type;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default settings: directed frames
        write_config(RST_START_BYTE, RST_RX_TYPE, RST_AT_TYPE);
        send_frame(16'd13, cur_rx, FILL_ZERO, 1'b0);
        hold_req = 1'b1;
        send_frame(16'd64, cur_rx, FILL_ONES, 1'b0);
        send_frame(16'd6, cur_at, FILL_RANDOM, 1'b0);
        send_frame(16'd14, cur_rx, FILL_START, 1'b0);
        send_frame(16'd3, cur_at, FILL_RANDOM, 1'b0);
        send_frame(16'd0, cur_at, FILL_RANDOM, 1'b0);
        send_frame(16'd1, cur_at, FILL_RANDOM, 1'b0);
        send_frame(16'd12, cur_rx, FILL_RANDOM, 1'b0);
        send_frame(16'd1, cur_rx, FILL_RANDOM, 1'b0);
        send_frame(16'd14, cur_rx, FILL_RANDOM, 1'b1);
        send_frame(16'd6, cur_at, FILL_RANDOM, 1'b1);
        send_frame(16'd65, cur_rx, FILL_RANDOM, 1'b0);
        send_frame(16'hFFFF, cur_at, FILL_RANDOM, 1'b0);
        send_frame(16'd10, 8'h00, FILL_RANDOM, 1'b0);
        drain();

        // low extremes for start and AT type, high for receive type
        write_config(8'h00, 8'hFF, 8'h00);
        random_traffic(PHASE_BYTES);
        drain();

        // opposite extremes, no idling on either side
        steady = 1'b1;
        write_config(8'hFF, 8'h00, 8'hFF);
        random_traffic(STEADY_BYTES);
        drain();
        steady = 1'b0;

        // both type registers equal: frames are taken as receive frames
        same_type = 8'($urandom_range(0, 255));
        write_config(8'($urandom_range(0, 255)), same_type, same_type);
        send_frame(16'd14, same_type, FILL_RANDOM, 1'b0);
        send_frame(16'd6, same_type, FILL_RANDOM, 1'b0);
        random_traffic(PHASE_BYTES);
        drain();

        // random settings
        write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        random_traffic(PHASE_BYTES);
        drain();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
